/* hw/rtl/swa_pkg.sv */
`timescale 1ns / 1ps

package swa_pkg;

  // Fixed field widths of the request and result.
  localparam int CNT_W  = 7;
  localparam int AVG_W  = 24;
  localparam int FRAC_W = 8;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

  // Reset value of the window length register.
  localparam logic [CNT_W-1:0] WINDOW_LENGTH_RESET = CNT_W'(1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic read_ring;
    logic update;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

/* hw/rtl/swa_ctrl.sv */
`timescale 1ns / 1ps

module swa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  swa_pkg::dp_status_t   status,
  output swa_pkg::dp_cmd_t      cmd
);
  import swa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands and input handshake.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_READ:   cmd.read_ring = 1'b1;
      ST_UPDATE: cmd.update    = 1'b1;
      ST_DIVIDE: cmd.div_step  = 1'b1;
      ST_DONE:   cmd.load_out  = out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/swa_dpath.sv */
`timescale 1ns / 1ps

module swa_dpath #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swa_pkg::dp_cmd_t                  cmd,
  output swa_pkg::dp_status_t               status,
  input  logic                              cfg_wr,
  input  logic [swa_pkg::CNT_W-1:0]         cfg_data,
  output logic [swa_pkg::CNT_W-1:0]         window_length,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic signed [swa_pkg::AVG_W-1:0]  average,
  output logic [swa_pkg::CNT_W-1:0]         samples_held
);
  import swa_pkg::*;

  localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DIV_W);

  // Architectural state.
  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic [AW-1:0]                 wpos;
  logic [CNT_W-1:0]              held;
  logic signed [SUM_W-1:0]       sum;

  // Per-request working registers.
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic [AW-1:0]                 pos;
  logic                          full;
  logic                          neg;
  logic [DIV_W-1:0]              quo;
  logic [CNT_W:0]                rem;
  logic [CNT_W-1:0]              divisor;
  logic [STEP_W-1:0]             step;

  logic [CNT_W-1:0]              win;
  logic [CNT_W-1:0]              win_raw;
  logic [AW-1:0]                 pos_eff;
  logic [AW-1:0]                 pos_inc;
  logic signed [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]              mag;
  logic [CNT_W-1:0]              held_next;
  logic [CNT_W:0]                rem_shift;
  logic                          rem_ge;
  logic [DIV_W:0]                q_signed;

  // Effective window: zero acts as one, and the length saturates at the ring depth.
  always_comb begin
    win_raw = (window_length == '0) ? CNT_W'(1) : window_length;
    win     = (int'(win_raw) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : win_raw;
  end

  // Slot for this request and the slot after it, both wrapped at the window.
  always_comb begin
    pos_eff = (int'(wpos) >= int'(win)) ? '0 : wpos;
    pos_inc = (int'(pos) + 1 >= int'(win)) ? '0 : AW'(int'(pos) + 1);
  end

  // New running sum, dropping the oldest sample once the window is full.
  always_comb begin
    sum_next = sum + SUM_W'(smp);
    if (full) begin
      sum_next = sum_next - SUM_W'(old_smp);
    end
    mag       = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    held_next = full ? win : held + CNT_W'(1);
  end

  // One restoring division step per cycle.
  always_comb begin
    rem_shift     = {rem[CNT_W-1:0], quo[DIV_W-1]};
    rem_ge        = rem_shift >= {1'b0, divisor};
    status.div_last = (step == '0);
    q_signed      = neg ? -{1'b0, quo} : {1'b0, quo};
  end

  // Sample ring: one write and one registered read.
  always_ff @(posedge clk) begin
    if (cmd.read_ring) begin
      old_smp <= ring[pos];
    end
    if (cmd.update) begin
      ring[pos] <= smp;
    end
  end

  // Window state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      wpos          <= '0;
      held          <= '0;
      sum           <= '0;
    end else if (cfg_wr) begin
      window_length <= cfg_data;
      wpos          <= '0;
      held          <= '0;
      sum           <= '0;
    end else if (cmd.update) begin
      wpos <= pos_inc;
      held <= held_next;
      sum  <= sum_next;
    end
  end

  // Request capture, divider and result register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp  <= sample;
      pos  <= pos_eff;
      full <= held >= win;
    end
    if (cmd.update) begin
      neg     <= sum_next[SUM_W-1];
      quo     <= {mag, FRAC_W'(0)};
      rem     <= '0;
      divisor <= held_next;
      step    <= STEP_W'(DIV_W - 1);
    end
    if (cmd.div_step) begin
      quo  <= {quo[DIV_W-2:0], rem_ge};
      rem  <= rem_ge ? rem_shift - {1'b0, divisor} : rem_shift;
      step <= step - STEP_W'(1);
    end
    if (cmd.load_out) begin
      average      <= AVG_W'($signed(q_signed));
      samples_held <= divisor;
    end
  end

endmodule

/* hw/rtl/sliding_window_average_core.sv */
`timescale 1ns / 1ps
// A request passes through the read, update, divide and done states; the
// radix-2 restoring divider gives one quotient bit a cycle.
// A new request is taken only once the previous result has reached the output register.
// A finished result waits in the output register while the next request runs.
// Synchronous active-high reset empties the window and sets window_length to 1.

module sliding_window_average_core #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swa_pkg::PADDR_W-1:0]         paddr,
  input  logic [swa_pkg::PDATA_W-1:0]         pwdata,
  output logic [swa_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swa_pkg::AVG_W-1:0]    average,
  output logic [swa_pkg::CNT_W-1:0]           samples_held
);
  import swa_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             cfg_hit;
  logic             cfg_wr;
  logic [CNT_W-1:0] window_length;

  // Register decode; a write lands in the access phase.
  assign pready  = 1'b1;
  assign cfg_hit = paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH;
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? PDATA_W'(window_length) : '0;

  swa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  swa_dpath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr        (cfg_wr),
    .cfg_data      (pwdata[CNT_W-1:0]),
    .window_length (window_length),
    .sample        (sample),
    .average       (average),
    .samples_held  (samples_held)
  );

endmodule

/* hw/rtl/swa_checker.sv */
`timescale 1ns / 1ps

module swa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [swa_pkg::AVG_W-1:0]  average,
  input logic [swa_pkg::CNT_W-1:0]         samples_held
);
  import swa_pkg::*;

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average) && $stable(samples_held))
    else $error("stalled result changed");

  // Every result averages at least one sample.
  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> samples_held != '0)
    else $error("result with no samples held");

  // One request at a time: after an accept the input side stalls.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // A new result only appears while a request is in progress.
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

endmodule

bind sliding_window_average_core swa_checker u_swa_checker (.*);

/* test/sliding_window_average_checker.sv */
`timescale 1ns / 1ps

module sliding_window_average_checker #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [swa_pkg::PADDR_W-1:0]       paddr,
  input  logic [swa_pkg::PDATA_W-1:0]       pwdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [swa_pkg::AVG_W-1:0]  average,
  input  logic [swa_pkg::CNT_W-1:0]         samples_held,
  output int                                errors,
  output int                                pending
);

  import swa_pkg::*;

  // Expected results wait in a small circular buffer.
  localparam int MEAN_DEPTH = 8;
  localparam int MEAN_AW    = 3;

  // One expected result: the window mean and how many samples it covers.
  typedef struct {
    logic signed [AVG_W-1:0] average;
    logic [CNT_W-1:0]        held;
  } window_mean_t;

  // Shadow of the window state.
  logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
  logic [CNT_W-1:0]              win_len;
  int unsigned                   wr_pos;
  int unsigned                   held_cnt;
  longint                        window_sum;

  window_mean_t       mean_buf [MEAN_DEPTH];
  logic [MEAN_AW-1:0] mean_rd = '0;
  logic [MEAN_AW-1:0] mean_wr = '0;
  int                 mean_cnt = 0;
  int                 fail_count = 0;

  assign errors  = fail_count;
  assign pending = mean_cnt;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // A window length of zero acts as one; lengths past the ring saturate.
  function automatic int unsigned active_window();
    int unsigned w;
    w = win_len;
    if (w == 0) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    return w;
  endfunction

  function automatic void empty_window();
    wr_pos     = 0;
    held_cnt   = 0;
    window_sum = 0;
  endfunction

  // Add one sample to the window and store the mean that it produces.
  task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int unsigned  w;
    int unsigned  pos;
    longint       scaled;
    window_mean_t m;
    w   = active_window();
    pos = wr_pos;
    if (pos >= w) pos = 0;
    if (held_cnt >= w) begin
      // Full window: the oldest sample sits where the new one goes.
      window_sum -= ring[pos];
      held_cnt = w;
    end else begin
      held_cnt++;
    end
    ring[pos] = s;
    window_sum += s;
    pos++;
    if (pos >= w) pos = 0;
    wr_pos = pos;
    scaled = (window_sum * (longint'(1) << FRAC_W)) / longint'(held_cnt);
    m.average = scaled[AVG_W-1:0];
    m.held    = held_cnt[CNT_W-1:0];
    if (mean_cnt == MEAN_DEPTH) begin
      report_mismatch("more requests in flight than the block can hold");
    end else begin
      mean_buf[mean_wr] = m;
      mean_wr++;
      mean_cnt++;
    end
  endtask

  // Results are retired before new requests, since a result in the same
  // cycle always belongs to an older request.
  always @(posedge clk) begin
    window_mean_t m;
    if (rst) begin
      win_len = WINDOW_LENGTH_RESET;
      empty_window();
      mean_rd  = '0;
      mean_wr  = '0;
      mean_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mean_cnt == 0) begin
          report_mismatch($sformatf("result with none expected: average %0d, held %0d",
                                    average, samples_held));
        end else begin
          m = mean_buf[mean_rd];
          mean_rd++;
          mean_cnt--;
          if (average !== m.average)
            report_mismatch($sformatf("average got %0d, expected %0d", average, m.average));
          if (samples_held !== m.held)
            report_mismatch($sformatf("samples_held got %0d, expected %0d",
                                      samples_held, m.held));
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH) begin
        win_len = pwdata[CNT_W-1:0];
        empty_window();
      end
      if (in_valid && !in_stall) take_sample(sample);
    end
  end

endmodule

/* test/tb_sliding_window_average_core.sv */
`timescale 1ns / 1ps

module tb_sliding_window_average_core;

  import swa_pkg::*;

  localparam int WINDOW_MAX     = 64;
  localparam int SAMPLE_W       = 16;
  localparam int TOTAL_SAMPLES  = 1300;
  localparam int STEADY_FROM    = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 50;

  // An index with no register behind it.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_WINDOW_LENGTH + 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [PADDR_W-1:0]          paddr = '0;
  logic [PDATA_W-1:0]          pwdata = '0;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [AVG_W-1:0]     average;
  logic [CNT_W-1:0]            samples_held;

  int errors;
  int pending;
  int sent_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  sliding_window_average_core #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average),
    .samples_held(samples_held)
  );

  sliding_window_average_checker #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_W)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average),
    .samples_held(samples_held),
    .errors      (errors),
    .pending     (pending)
  );

  // Result side backpressure in random bursts.
  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Setup and access cycles of one register write.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random upper bits ride along with the length; the block ignores them.
  task automatic set_window(input logic [CNT_W-1:0] len);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[CNT_W-1:0] = len;
    drain();
    write_reg(REG_WINDOW_LENGTH, word);
  endtask

  // Present one request, with an occasional gap in front of it.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    int                         len;
    int                         span;
    int                         n_items;
    int                         pattern;
    logic signed [SAMPLE_W-1:0] value;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset window of one, then zero, an ignored index, a short
    // window that wraps, and a saturated length.
    send_gap_pct = 20;
    stall_pct = 20;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    set_window(7'd0);
    send_sample(-16'sd300);
    send_sample(16'sd300);
    drain();
    write_reg(REG_SPARE, 32'hffff_ff05);
    send_sample(16'sd7);
    set_window(7'd3);
    repeat (4) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    set_window(7'd127);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    // Full window at both extremes of the mean.
    set_window(7'd64);
    repeat (66) send_sample(SAMPLE_MAX);
    repeat (66) send_sample(SAMPLE_MIN);

    // Random phases: a new window length, then a run of samples long
    // enough to fill and wrap it most of the time.
    while (sent_count < TOTAL_SAMPLES) begin
      case ($urandom_range(0, 5))
        0: len = 0;
        1: len = 1;
        2: len = WINDOW_MAX;
        3: len = $urandom_range(WINDOW_MAX + 1, 127);
        default: len = $urandom_range(2, WINDOW_MAX - 1);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        drain();
        write_reg(REG_SPARE, $urandom());
      end
      set_window(len[CNT_W-1:0]);
      span = (len == 0) ? 1 : (len > WINDOW_MAX) ? WINDOW_MAX : len;
      n_items = $urandom_range(1, 2 * span + 8);
      pattern = $urandom_range(0, 4);
      if (sent_count >= STEADY_FROM) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: send_gap_pct = 0;
          1: send_gap_pct = 15;
          default: send_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      for (int k = 0; k < n_items; k++) begin
        case (pattern)
          0: value = SAMPLE_W'($urandom());
          1: value = SAMPLE_MAX;
          2: value = SAMPLE_MIN;
          3: value = SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
          default: value = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN)
                                                 : SAMPLE_W'($urandom());
        endcase
        send_sample(value);
        // Now and then hold off until the block has caught up.
        if ($urandom_range(0, 63) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
